[rtl/core/lcnc_pkg.sv]
// ---------------------------------------------------------------------------
// lcnc_pkg: shared definitions of the Luhn card number classifier
// Field widths, class codes, prefix limits, sequencer states and the
// control and status bundles between the top level and the BCD converter.
// ---------------------------------------------------------------------------
package lcnc_pkg;

	// Field widths of one request and one result.
	localparam int CARD_W     = 63;
	localparam int DATA_IN_W  = 64;
	localparam int CLS_W      = 2;
	localparam int CNT_W      = 5;
	localparam int PAIR_W     = 7;
	localparam int DATA_OUT_W = 16;

	// Default number of digits that are scanned.
	localparam int MAX_DIGITS_DEF = 19;

	// Binary to BCD converter: 19 digits hold any 63-bit value.
	localparam int BCD_DIGITS = 19;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int DAB_BITS   = 8;
	localparam int DAB_STEPS  = 8;
	localparam int DAB_CNT_W  = 3;
	localparam int BIN_W      = DAB_BITS * DAB_STEPS;

	// Result classes.
	localparam logic [CLS_W-1:0] CLS_INVALID = 2'd0;
	localparam logic [CLS_W-1:0] CLS_BRAND_A = 2'd1;
	localparam logic [CLS_W-1:0] CLS_BRAND_B = 2'd2;
	localparam logic [CLS_W-1:0] CLS_BRAND_C = 2'd3;

	// Length and prefix rules.
	localparam logic [CNT_W-1:0]  LEN_A      = 5'd16;
	localparam logic [PAIR_W-1:0] PFX_A_LO   = 7'd51;
	localparam logic [PAIR_W-1:0] PFX_A_HI   = 7'd55;
	localparam logic [CNT_W-1:0]  LEN_B      = 5'd15;
	localparam logic [PAIR_W-1:0] PFX_B_0    = 7'd34;
	localparam logic [PAIR_W-1:0] PFX_B_1    = 7'd37;
	localparam logic [CNT_W-1:0]  LEN_C_0    = 5'd13;
	localparam logic [CNT_W-1:0]  LEN_C_1    = 5'd16;
	localparam logic [3:0]        LEAD_C     = 4'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_FIN
	} lcnc_state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} lcnc_conv_ctl_t;

	typedef struct packed {
		logic       busy;
		logic       too_long;
		logic [3:0] digit;
	} lcnc_conv_sts_t;

	// Digit sum of twice a decimal digit.
	function automatic logic [3:0] luhn_double(input logic [3:0] d);
		logic [3:0] r;
		case (d)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd2;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd6;
			4'd4:    r = 4'd8;
			4'd5:    r = 4'd1;
			4'd6:    r = 4'd3;
			4'd7:    r = 4'd5;
			4'd8:    r = 4'd7;
			4'd9:    r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/lcnc_b2bcd.sv]
// ---------------------------------------------------------------------------
// lcnc_b2bcd: iterative binary to BCD converter
// Shift-and-add-3 conversion, eight bits per cycle, then hands out the
// digits least significant first, one per shift command.
// ---------------------------------------------------------------------------
module lcnc_b2bcd #(
	parameter int MAX_DIGITS = lcnc_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lcnc_pkg::lcnc_conv_ctl_t    ctl,
	input  logic [lcnc_pkg::CARD_W-1:0] bin,
	output lcnc_pkg::lcnc_conv_sts_t    sts
);
	import lcnc_pkg::*;

	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [DAB_CNT_W-1:0] step_q;
	logic                 busy_q;
	logic [BIN_W-1:0]     bin_nxt;
	logic [BCD_W-1:0]     bcd_nxt;
	logic                 too_long;

	always_comb begin
		logic [BCD_W-1:0] b;
		logic [BIN_W-1:0] r;
		b = bcd_q;
		r = bin_q;
		for (int s = 0; s < DAB_BITS; s++) begin
			for (int k = 0; k < BCD_DIGITS; k++) begin
				if (b[4*k +: 4] >= 4'd5) begin
					b[4*k +: 4] = b[4*k +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], r[BIN_W-1]};
			r = {r[BIN_W-2:0], 1'b0};
		end
		bcd_nxt = b;
		bin_nxt = r;
	end

	// Any nonzero digit beyond the scanned range marks the number too long.
	always_comb begin
		too_long = 1'b0;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (k >= MAX_DIGITS) begin
				too_long = too_long | (|bcd_q[4*k +: 4]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + DAB_CNT_W'(1);
			if (step_q == DAB_CNT_W'(DAB_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= BIN_W'(bin);
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_nxt;
			bcd_q <= bcd_nxt;
		end else if (ctl.shift) begin
			bcd_q <= {4'd0, bcd_q[BCD_W-1:4]};
		end
	end

	assign sts.busy     = busy_q;
	assign sts.too_long = too_long;
	assign sts.digit    = bcd_q[3:0];

endmodule

[rtl/core/luhn_card_number_classifier.sv]
// ---------------------------------------------------------------------------
// luhn_card_number_classifier: Luhn mod-10 check and brand classification
// Converts a binary card number to decimal, checks the Luhn sum, counts the
// digits, takes the leading pair and sorts the number into a brand class.
// ---------------------------------------------------------------------------
// One request is taken at a time: the block is not ready for another card
// number until it is through with the last one. The 63-bit number is first
// converted to BCD,
// eight bits per cycle through one shift-and-add-3 unit; then one digit per
// cycle, least significant first, passes the Luhn accumulator, which keeps
// the sum modulo ten with one add and one compare-subtract. The digit scan
// over MAX_DIGITS positions sets the bulk of the latency. A finished result
// sits in an output register, so the next card number is accepted while
// the previous result still waits for the consumer. Zero reads as invalid
// with a count of zero and a passing checksum; a number with more digits
// than MAX_DIGITS reads as invalid with a count of MAX_DIGITS + 1.
module luhn_card_number_classifier #(
	parameter int MAX_DIGITS = lcnc_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_axis_tdata: card_number [62:0], zero [63]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lcnc_pkg::DATA_IN_W-1:0]  s_axis_tdata,
	// m_axis_tdata: card_class [1:0], checksum_ok [2], digit_count [7:3],
	// leading_pair [14:8], zero [15]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lcnc_pkg::DATA_OUT_W-1:0] m_axis_tdata
);
	import lcnc_pkg::*;

	lcnc_state_t    state_q;
	lcnc_state_t    state_nxt;
	lcnc_conv_ctl_t conv_ctl;
	lcnc_conv_sts_t conv_sts;

	logic                  fin_go;
	logic [CNT_W-1:0]      idx_q;
	logic [3:0]            sum_q;
	logic [CNT_W-1:0]      count_q;
	logic [3:0]            top_q;
	logic [3:0]            below_q;
	logic [3:0]            prev_q;
	logic                  too_long_q;
	logic                  out_valid_q;
	logic [DATA_OUT_W-1:0] out_data_q;

	logic [3:0]        addend;
	logic [4:0]        sum_raw;
	logic [3:0]        sum_nxt;
	logic [PAIR_W-1:0] pair;
	logic              ok;
	logic [CLS_W-1:0]  cls;
	logic [CLS_W-1:0]  res_cls;
	logic              res_ok;
	logic [CNT_W-1:0]  res_count;
	logic [PAIR_W-1:0] res_pair;

	lcnc_b2bcd #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_b2bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (conv_ctl),
		.bin    (s_axis_tdata[CARD_W-1:0]),
		.sts    (conv_sts)
	);

	// Sequencer: next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (!conv_sts.busy) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == CNT_W'(MAX_DIGITS - 1)) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		s_axis_tready  = 1'b0;
		conv_ctl.load  = 1'b0;
		conv_ctl.shift = 1'b0;
		fin_go         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				conv_ctl.load = s_axis_tvalid;
			end
			ST_CONV: begin
			end
			ST_SCAN: begin
				conv_ctl.shift = 1'b1;
			end
			ST_FIN: begin
				fin_go = !out_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Luhn accumulator: odd positions from the right add the digit, even
	// positions add the digit sum of its double. The sum is kept modulo ten.
	assign addend  = idx_q[0] ? luhn_double(conv_sts.digit) : conv_sts.digit;
	assign sum_raw = {1'b0, sum_q} + {1'b0, addend};
	assign sum_nxt = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (conv_ctl.load) begin
			idx_q <= '0;
		end else if (conv_ctl.shift) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (conv_ctl.load) begin
			sum_q   <= '0;
			count_q <= '0;
			top_q   <= '0;
			below_q <= '0;
			prev_q  <= '0;
		end else if (conv_ctl.shift) begin
			sum_q  <= sum_nxt;
			prev_q <= conv_sts.digit;
			// The most significant nonzero digit so far fixes the length
			// and the leading pair; leading zeros never reach it.
			if (conv_sts.digit != 4'd0) begin
				count_q <= idx_q + CNT_W'(1);
				top_q   <= conv_sts.digit;
				below_q <= prev_q;
			end
		end
		if (state_q == ST_CONV && !conv_sts.busy) begin
			too_long_q <= conv_sts.too_long;
		end
	end

	// Leading pair: nothing for zero, the digit itself for one digit.
	always_comb begin
		if (count_q == CNT_W'(0)) begin
			pair = '0;
		end else if (count_q == CNT_W'(1)) begin
			pair = PAIR_W'(top_q);
		end else begin
			pair = PAIR_W'({top_q, 3'b000}) + PAIR_W'({top_q, 1'b0}) + PAIR_W'(below_q);
		end
	end

	assign ok = (sum_q == 4'd0);

	// Classes are tried in the order brand A, brand B, brand C.
	always_comb begin
		cls = CLS_INVALID;
		if (ok) begin
			if (count_q == LEN_A && pair >= PFX_A_LO && pair <= PFX_A_HI) begin
				cls = CLS_BRAND_A;
			end else if (count_q == LEN_B && (pair == PFX_B_0 || pair == PFX_B_1)) begin
				cls = CLS_BRAND_B;
			end else if ((count_q == LEN_C_0 || count_q == LEN_C_1) && top_q == LEAD_C) begin
				cls = CLS_BRAND_C;
			end
		end
	end

	always_comb begin
		if (too_long_q) begin
			res_cls   = CLS_INVALID;
			res_ok    = 1'b0;
			res_count = CNT_W'(MAX_DIGITS + 1);
			res_pair  = '0;
		end else begin
			res_cls   = cls;
			res_ok    = ok;
			res_count = count_q;
			res_pair  = pair;
		end
	end

	// Output register: holds the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_data_q <= {1'b0, res_pair, res_count, res_ok, res_cls};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[rtl/core/lcnc_checker.sv]
// ---------------------------------------------------------------------------
// lcnc_checker: port-level checks of the Luhn card number classifier
// Watches the stream ports and flags results or handshakes that the
// sequencer and classifier can never produce.
// ---------------------------------------------------------------------------
module lcnc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lcnc_pkg::DATA_OUT_W-1:0] m_axis_tdata
);
	import lcnc_pkg::*;

	// One request at a time: the block is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while previous one is in work");

	// A waiting result holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// A new result only appears as the sequencer leaves its final step.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without work in progress");

	// Any brand class requires a passing checksum.
	a_class_needs_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != CLS_INVALID |-> m_axis_tdata[2])
		else $error("brand class with failing checksum");

	// Brand A is always sixteen digits long.
	a_brand_a_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == CLS_BRAND_A |-> m_axis_tdata[7:3] == LEN_A)
		else $error("brand A with wrong digit count");

endmodule

bind luhn_card_number_classifier lcnc_checker u_lcnc_checker (.*);
